// ===== rtl/core/scc_pkg.sv =====
// Shared constants, types and request/response structs of the spectral color classifier.
// No dependencies; every other file of the block imports this package.
package scc_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int BAND_COUNT  = 8;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int BAND_W      = 16;
  localparam int DIST_W      = 20;
  localparam int WGT_W       = 33;
  localparam int TOT_W       = 35;
  localparam int PCT_W       = 7;
  localparam int DIV_NUM_W   = 41;
  localparam int DIV_DEN_W   = 36;
  localparam int DIV_CNT_W   = 6;
  localparam int ROW_W       = BAND_COUNT * BAND_W;

  localparam logic [CNT_W-1:0]     ENTRIES_RESET = CNT_W'(19);
  localparam logic [CNT_W-1:0]     ENTRIES_MIN   = CNT_W'(3);
  localparam logic [CNT_W-1:0]     ENTRIES_MAX   = CNT_W'(MAX_ENTRIES);
  localparam logic [DIV_CNT_W-1:0] NORM_BITS     = DIV_CNT_W'(32);
  localparam logic [DIV_CNT_W-1:0] WGT_BITS      = DIV_CNT_W'(33);
  localparam logic [DIV_CNT_W-1:0] PCT_BITS      = DIV_CNT_W'(41);

  typedef logic [BAND_COUNT-1:0][BAND_W-1:0] band_arr_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [2:0][DIST_W-1:0] dists;
    logic [2:0][IDX_W-1:0]  idx;
  } rank_t;

endpackage

// ===== rtl/core/scc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on scc_pkg.
module scc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scc_pkg::div_req_t req_i,
  output scc_pkg::div_rsp_t rsp_o
);
  import scc_pkg::*;

  logic                 busy_q, busy_d, done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 qbit;

  always_comb begin
    rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
    qbit   = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      num_d  = req_i.num << (DIV_CNT_W'(DIV_NUM_W) - req_i.nbits);
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = qbit ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : DIV_DEN_W'(rem_sh);
      num_d = {num_q[DIV_NUM_W-2:0], qbit};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !done_q)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && !$past(done_q))
    else $error("divider done is not a single pulse");
  a_nbits_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.nbits != '0)
    else $error("divider started with zero bits");

endmodule

// ===== rtl/core/scc_ref_mem.sv =====
// Reference spectrum memory: one row of all bands per entry, registered read.
// Depends on scc_pkg.
module scc_ref_mem (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [scc_pkg::IDX_W-1:0] waddr_i,
  input  scc_pkg::band_arr_t      wdata_i,
  input  logic                    re_i,
  input  logic [scc_pkg::IDX_W-1:0] raddr_i,
  output scc_pkg::band_arr_t      rdata_o
);
  import scc_pkg::*;

  logic [ROW_W-1:0] mem [MAX_ENTRIES];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/scc_rank.sv =====
// L1 distance of one reference row per cycle and the running three nearest entries.
// Depends on scc_pkg.
module scc_rank (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      vld_i,
  input  logic [scc_pkg::IDX_W-1:0] idx_i,
  input  scc_pkg::band_arr_t        row_i,
  input  scc_pkg::band_arr_t        bands_i,
  output scc_pkg::rank_t            rank_o
);
  import scc_pkg::*;

  logic [DIST_W-1:0] sum;
  logic [DIST_W-1:0] d_q;
  logic [IDX_W-1:0]  i_q;
  logic              v_q;
  rank_t             rank_q, rank_d;

  always_comb begin
    sum = '0;
    for (int b = 0; b < BAND_COUNT; b++) begin
      if (bands_i[b] >= row_i[b]) begin
        sum = sum + DIST_W'(bands_i[b] - row_i[b]);
      end else begin
        sum = sum + DIST_W'(row_i[b] - bands_i[b]);
      end
    end
  end

  always_comb begin
    rank_d = rank_q;
    if (clr_i) begin
      rank_d.dists = '1;
      rank_d.idx   = '0;
    end else if (v_q && d_q < rank_q.dists[2]) begin
      if (d_q < rank_q.dists[0]) begin
        rank_d.dists = {rank_q.dists[1], rank_q.dists[0], d_q};
        rank_d.idx   = {rank_q.idx[1], rank_q.idx[0], i_q};
      end else if (d_q < rank_q.dists[1]) begin
        rank_d.dists[2] = rank_q.dists[1];
        rank_d.idx[2]   = rank_q.idx[1];
        rank_d.dists[1] = d_q;
        rank_d.idx[1]   = i_q;
      end else begin
        rank_d.dists[2] = d_q;
        rank_d.idx[2]   = i_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= vld_i && !clr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= sum;
    i_q    <= idx_i;
    rank_q <= rank_d;
  end

  assign rank_o = rank_q;

endmodule

// ===== rtl/core/spectral_color_classifier.sv =====
// Top level of the spectral color classifier: sequencer, band registers and output stage.
// Depends on scc_pkg, scc_div, scc_ref_mem and scc_rank.
//
//   channel   direction  handshake                     content
//   s_axis    in         s_axis_tvalid/s_axis_tready   write or classify item
//   m_axis    out        m_axis_tvalid/m_axis_tready   three nearest entries, shares, flags
//   cfg       in         cfg_valid_i/cfg_ready_o       entries_in_use
//
// A write transfer leaves the block idle and ready for the next item. A classify is paced
// by the one-bit-per-cycle divider that serves all normalizations, weights and shares;
// a zero clear reading skips the normalizations. The memory read walks one entry per
// cycle. Reset is asynchronous, active low; the reference memory has no reset. A result
// waiting in the output register does not block the next transfer; only the next
// finished classify waits for it.
module spectral_color_classifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index, band_1 .. band_8, clear_first, clear_second, zero pad
  input  logic [167:0] s_axis_tdata,
  // mode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // best_index, second_index, third_index, best_percent, second_percent,
  // third_percent, zero pad
  output logic [39:0]  m_axis_tdata,
  // clear_was_zero, band_wrapped
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [5:0]   cfg_data_i
);
  import scc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_DIST  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WGT   = 3'd4;
  localparam logic [2:0] S_PCT   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_q;
  logic [CNT_W-1:0]  entries_q, n_act;
  logic              issued_q;
  logic [2:0]        b_q;
  logic [IDX_W-1:0]  e_q;
  logic              drain_q;
  logic [1:0]        k_q;
  band_arr_t         bands_q, in_bands;
  logic [BAND_W-1:0] clear_q;
  logic [BAND_W:0]   clear_sum;
  logic              zero_q, wrap_q;
  logic [WGT_W-1:0]  w_q [3];
  logic [TOT_W-1:0]  total_q;
  logic [PCT_W-1:0]  pct_q [3];
  logic              out_valid_q;
  logic [39:0]       out_data_q;
  logic [1:0]        out_user_q;
  logic              s_acc, classify, mem_we, rd_en, rd_vld_q, out_load;
  logic [IDX_W-1:0]  rd_idx_q;
  band_arr_t         row;
  rank_t             rank;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DIV_NUM_W-1:0] w_ext;
  logic [8:0]        pct_sum;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign classify      = s_acc && s_axis_tuser[0];
  assign mem_we        = s_acc && !s_axis_tuser[0];
  assign cfg_ready_o   = 1'b1;
  assign rd_en         = (state_q == S_DIST);
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign clear_sum     = {1'b0, s_axis_tdata[148:133]} + {1'b0, s_axis_tdata[164:149]};

  always_comb begin
    for (int b = 0; b < BAND_COUNT; b++) begin
      in_bands[b] = s_axis_tdata[5 + BAND_W*b +: BAND_W];
    end
  end

  always_comb begin
    if (entries_q < ENTRIES_MIN) begin
      n_act = ENTRIES_MIN;
    end else if (entries_q > ENTRIES_MAX) begin
      n_act = ENTRIES_MAX;
    end else begin
      n_act = entries_q;
    end
  end

  assign w_ext = DIV_NUM_W'(w_q[k_q]);

  always_comb begin
    div_req.start = ((state_q == S_NORM) || (state_q == S_WGT) || (state_q == S_PCT))
                    && !issued_q;
    div_req.num   = '0;
    div_req.den   = '0;
    div_req.nbits = NORM_BITS;
    unique case (state_q)
      S_NORM: begin
        div_req.num   = DIV_NUM_W'({bands_q[b_q], 16'd0} - {16'd0, bands_q[b_q]});
        div_req.den   = DIV_DEN_W'(clear_q);
        div_req.nbits = NORM_BITS;
      end
      S_WGT: begin
        div_req.num   = DIV_NUM_W'(1) << 32;
        div_req.den   = DIV_DEN_W'(rank.dists[k_q]) + DIV_DEN_W'(1);
        div_req.nbits = WGT_BITS;
      end
      S_PCT: begin
        div_req.num   = (w_ext << 7) + (w_ext << 6) + (w_ext << 3)
                        + DIV_NUM_W'(total_q);
        div_req.den   = DIV_DEN_W'({total_q, 1'b0});
        div_req.nbits = PCT_BITS;
      end
      default: begin
        div_req.num = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= ENTRIES_RESET;
      issued_q    <= 1'b0;
      b_q         <= '0;
      e_q         <= '0;
      drain_q     <= 1'b0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cfg_valid_i && cfg_ready_o) begin
        entries_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (div_req.start) begin
        issued_q <= 1'b1;
      end else if (div_rsp.done) begin
        issued_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (classify) begin
            b_q <= '0;
            e_q <= '0;
            state_q <= (clear_sum[BAND_W:1] == '0) ? S_DIST : S_NORM;
          end
        end
        S_NORM: begin
          if (div_rsp.done) begin
            if (b_q == 3'(BAND_COUNT - 1)) begin
              state_q <= S_DIST;
            end else begin
              b_q <= b_q + 3'd1;
            end
          end
        end
        S_DIST: begin
          if ({1'b0, e_q} == n_act - CNT_W'(1)) begin
            drain_q <= 1'b0;
            state_q <= S_DRAIN;
          end else begin
            e_q <= e_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            k_q     <= '0;
            state_q <= S_WGT;
          end
        end
        S_WGT: begin
          if (div_rsp.done) begin
            if (k_q == 2'd2) begin
              k_q     <= '0;
              state_q <= S_PCT;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        S_PCT: begin
          if (div_rsp.done) begin
            if (k_q == 2'd2) begin
              state_q <= S_DONE;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= e_q;
    if (classify) begin
      bands_q <= in_bands;
      clear_q <= clear_sum[BAND_W:1];
      zero_q  <= (clear_sum[BAND_W:1] == '0);
      wrap_q  <= 1'b0;
    end
    if (state_q == S_NORM && div_rsp.done) begin
      bands_q[b_q] <= div_rsp.quot[BAND_W-1:0];
      if (div_rsp.quot[31:16] != '0) begin
        wrap_q <= 1'b1;
      end
    end
    if (state_q == S_WGT && div_rsp.done) begin
      w_q[k_q] <= div_rsp.quot[WGT_W-1:0];
      if (k_q == 2'd2) begin
        total_q <= TOT_W'(w_q[0]) + TOT_W'(w_q[1]) + TOT_W'(div_rsp.quot[WGT_W-1:0]);
      end
    end
    if (state_q == S_PCT && div_rsp.done) begin
      pct_q[k_q] <= div_rsp.quot[PCT_W-1:0];
    end
    if (out_load) begin
      out_data_q <= {4'd0, pct_q[2], pct_q[1], pct_q[0],
                     rank.idx[2], rank.idx[1], rank.idx[0]};
      out_user_q <= {wrap_q, zero_q};
    end
  end

  scc_ref_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s_axis_tdata[IDX_W-1:0]),
    .wdata_i (in_bands),
    .re_i    (rd_en),
    .raddr_i (e_q),
    .rdata_o (row)
  );

  scc_rank u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (classify),
    .vld_i   (rd_vld_q),
    .idx_i   (rd_idx_q),
    .row_i   (row),
    .bands_i (bands_q),
    .rank_o  (rank)
  );

  scc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign pct_sum = 9'(pct_q[0]) + 9'(pct_q[1]) + 9'(pct_q[2]);

  a_mem_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_IDLE && !div_rsp.busy)
    else $error("reference write while classifying");
  a_rank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> rank.dists[0] <= rank.dists[1] && rank.dists[1] <= rank.dists[2])
    else $error("nearest entries out of order");
  a_pct_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> pct_sum >= 9'd99 && pct_sum <= 9'd101)
    else $error("weight shares do not add up to about 100");
  a_div_only_busy_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> state_q == S_NORM || state_q == S_WGT || state_q == S_PCT)
    else $error("divider running outside a division step");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for spectral_color_classifier: drives write and classify
// transfers, predicts each classification result and compares it field by field.
// Depends only on scc_pkg and the spectral_color_classifier RTL.
module tb;
  import scc_pkg::*;

  localparam logic MODE_WRITE    = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;
  localparam int   IDLE_LIMIT    = 4000;
  localparam int   DRAIN_CYCLES  = 700;

  typedef struct packed {
    logic [2:0][IDX_W-1:0] idx;
    logic [2:0][PCT_W-1:0] pct;
    logic                  clear_zero;
    logic                  wrapped;
  } match_t;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [39:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i, cfg_ready_o;
  logic [5:0]   cfg_data_i;

  logic [BAND_W-1:0] spectra_table [MAX_ENTRIES][BAND_COUNT];
  logic [CNT_W-1:0]  entries_reg;
  match_t            pending_matches [$];
  bit                quiet, failed;
  int                idle_cycles;

  spectral_color_classifier i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic match_t classify_spectrum(band_arr_t bands, logic [15:0] c1,
                                               logic [15:0] c2);
    match_t      r;
    logic [16:0] clear;
    logic [63:0] q, total;
    logic [63:0] w [3];
    logic [31:0] best_d [3];
    logic [4:0]  best_i [3];
    logic [31:0] d, td;
    logic [4:0]  ti;
    int          n;
    r = '0;
    clear = (17'(c1) + 17'(c2)) >> 1;
    if (clear == 0) begin
      r.clear_zero = 1'b1;
    end else begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        q = (64'(bands[b]) * 64'd65535) / 64'(clear);
        if (q > 64'd65535) r.wrapped = 1'b1;
        bands[b] = q[15:0];
      end
    end
    n = entries_reg < 3 ? 3 : (entries_reg > MAX_ENTRIES ? MAX_ENTRIES : int'(entries_reg));
    for (int k = 0; k < 3; k++) begin
      best_d[k] = '1;
      best_i[k] = '0;
    end
    for (int e = 0; e < n; e++) begin
      d = 0;
      for (int b = 0; b < BAND_COUNT; b++)
        d += bands[b] >= spectra_table[e][b] ? bands[b] - spectra_table[e][b]
                                             : spectra_table[e][b] - bands[b];
      if (d < best_d[2]) begin
        best_d[2] = d;
        best_i[2] = 5'(e);
        if (best_d[2] < best_d[1]) begin
          td = best_d[1]; ti = best_i[1];
          best_d[1] = best_d[2]; best_i[1] = best_i[2];
          best_d[2] = td; best_i[2] = ti;
          if (best_d[1] < best_d[0]) begin
            td = best_d[0]; ti = best_i[0];
            best_d[0] = best_d[1]; best_i[0] = best_i[1];
            best_d[1] = td; best_i[1] = ti;
          end
        end
      end
    end
    total = 0;
    for (int k = 0; k < 3; k++) begin
      w[k] = (64'd1 << 32) / (64'(best_d[k]) + 64'd1);
      total += w[k];
    end
    for (int k = 0; k < 3; k++) begin
      r.idx[k] = best_i[k];
      r.pct[k] = PCT_W'((64'd200 * w[k] + total) / (64'd2 * total));
    end
    return r;
  endfunction

  task automatic send_item(logic mode, logic [4:0] index, band_arr_t bands,
                           logic [15:0] c1, logic [15:0] c2);
    logic [167:0] data;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    data = '0;
    data[4:0] = index;
    for (int b = 0; b < BAND_COUNT; b++) data[5 + 16*b +: 16] = bands[b];
    data[133 +: 16] = c1;
    data[149 +: 16] = c2;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_WRITE) begin
      for (int b = 0; b < BAND_COUNT; b++) spectra_table[index][b] = bands[b];
    end else begin
      pending_matches.push_back(classify_spectrum(bands, c1, c2));
    end
  endtask

  task automatic write_entries_in_use(logic [5:0] value);
    s_axis_tvalid <= 1'b0;
    wait (pending_matches.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    entries_reg = value;
  endtask

  function automatic band_arr_t random_bands();
    band_arr_t b;
    for (int k = 0; k < BAND_COUNT; k++) b[k] = 16'($urandom);
    return b;
  endfunction

  task automatic test_load_table();
    for (int e = 0; e < MAX_ENTRIES; e++)
      send_item(MODE_WRITE, 5'(e), random_bands(), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_special_cases();
    band_arr_t b;
    b = random_bands();
    send_item(MODE_WRITE, 5'd0, b, '0, '0);
    send_item(MODE_WRITE, 5'd1, b, '0, '0);
    send_item(MODE_WRITE, 5'd2, b, '0, '0);
    send_item(MODE_CLASSIFY, 5'd0, b, 16'd0, 16'd0);
    send_item(MODE_CLASSIFY, 5'd0, b, 16'd0, 16'd1);
    send_item(MODE_CLASSIFY, 5'd31, b, 16'hFFFF, 16'hFFFF);
    send_item(MODE_CLASSIFY, 5'd0, '1, 16'hFFFF, 16'hFFFF);
    send_item(MODE_CLASSIFY, 5'd0, '0, 16'd5, 16'd9);
    send_item(MODE_CLASSIFY, 5'd0, '1, 16'd1, 16'd1);
    send_item(MODE_CLASSIFY, 5'd0, '1, 16'hFFFF, 16'd0);
    send_item(MODE_WRITE, 5'd31, '1, '1, '1);
    send_item(MODE_WRITE, 5'd30, '0, '0, '0);
    send_item(MODE_CLASSIFY, 5'd0, '1, 16'd0, 16'd0);
    send_item(MODE_CLASSIFY, 5'd0, '0, 16'd0, 16'd0);
  endtask

  task automatic test_entry_counts();
    logic [5:0] counts [6] = '{6'd0, 6'd3, 6'd32, 6'd63, 6'd2, 6'd33};
    foreach (counts[i]) begin
      write_entries_in_use(counts[i]);
      send_item(MODE_CLASSIFY, 5'd0, '1, 16'd0, 16'd0);
      send_item(MODE_CLASSIFY, 5'd0, '0, 16'd0, 16'd0);
      send_item(MODE_CLASSIFY, 5'($urandom), random_bands(), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_random(int items);
    band_arr_t b;
    logic [15:0] c1, c2;
    int e;
    for (int i = 0; i < items; i++) begin
      if (i == items / 3) write_entries_in_use(6'($urandom_range(3, 32)));
      if (i == 2 * items / 3) write_entries_in_use(6'd32);
      if (i >= items - 40) quiet = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        send_item(MODE_WRITE, 5'($urandom), random_bands(), 16'($urandom), 16'($urandom));
      end else begin
        e = $urandom_range(0, MAX_ENTRIES - 1);
        case ($urandom_range(0, 3))
          0: begin
            b = random_bands();
            c1 = 16'($urandom);
            c2 = 16'($urandom);
          end
          1: begin
            for (int k = 0; k < BAND_COUNT; k++)
              b[k] = spectra_table[e][k] + 16'($urandom_range(0, 40)) - 16'd20;
            c1 = 16'($urandom_range(0, 1));
            c2 = 16'd0;
          end
          2: begin
            for (int k = 0; k < BAND_COUNT; k++) b[k] = spectra_table[e][k];
            c1 = 16'hFFFF;
            c2 = 16'hFFFF - 16'($urandom_range(0, 1));
          end
          default: begin
            for (int k = 0; k < BAND_COUNT; k++) b[k] = 16'($urandom_range(0, 2000));
            c1 = 16'($urandom_range(0, 3000));
            c2 = 16'($urandom_range(0, 3000));
          end
        endcase
        send_item(MODE_CLASSIFY, 5'($urandom), b, c1, c2);
      end
    end
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    match_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.idx[0] = m_axis_tdata[4:0];
      got.idx[1] = m_axis_tdata[9:5];
      got.idx[2] = m_axis_tdata[14:10];
      got.pct[0] = m_axis_tdata[21:15];
      got.pct[1] = m_axis_tdata[28:22];
      got.pct[2] = m_axis_tdata[35:29];
      got.clear_zero = m_axis_tuser[0];
      got.wrapped    = m_axis_tuser[1];
      if (pending_matches.size() == 0) begin
        $error("result transfer with no classification pending");
        failed = 1'b1;
      end else begin
        want = pending_matches.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (got.idx[k] !== want.idx[k]) begin
            $error("index[%0d]: expected %0d, got %0d", k, want.idx[k], got.idx[k]);
            failed = 1'b1;
          end
          if (got.pct[k] !== want.pct[k]) begin
            $error("percent[%0d]: expected %0d, got %0d", k, want.pct[k], got.pct[k]);
            failed = 1'b1;
          end
        end
        if (got.clear_zero !== want.clear_zero) begin
          $error("clear_was_zero: expected %0d, got %0d", want.clear_zero, got.clear_zero);
          failed = 1'b1;
        end
        if (got.wrapped !== want.wrapped) begin
          $error("band_wrapped: expected %0d, got %0d", want.wrapped, got.wrapped);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** spectral_color_classifier: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    quiet         = 1'b0;
    failed        = 1'b0;
    entries_reg   = ENTRIES_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_table();
    test_special_cases();
    test_entry_counts();
    write_entries_in_use(6'd19);
    test_random(490);
    s_axis_tvalid <= 1'b0;
    wait (pending_matches.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed && pending_matches.size() == 0) begin
      $display("** spectral_color_classifier: PASSED **");
    end else begin
      $display("** spectral_color_classifier: FAILED **");
    end
    $finish;
  end
endmodule

// ===== spectral_color_classifier.f =====
rtl/core/scc_pkg.sv
rtl/core/scc_div.sv
rtl/core/scc_ref_mem.sv
rtl/core/scc_rank.sv
rtl/core/spectral_color_classifier.sv
tb/tb.sv
